// ===== design/hce_pkg.sv =====
// ============================================================================
// hce_pkg: shared types and constants of the Huffman code engine
// Request and response payloads, command and status codes, and the
// micro-operation codes passed from the controller to the datapath, and the status bits passed back.
// ============================================================================
`default_nettype none

package hce_pkg;

    localparam int ALPHABET_SIZE = 256;
    localparam int COUNT_WIDTH   = 16;
    localparam int MAX_CODE_LEN  = 32;
    localparam int SYM_W         = 8;
    localparam int NODE_W        = 9;
    localparam int CODE_W        = 32;
    localparam int LEN_W         = 6;

    localparam logic [2:0] CMD_COUNT  = 3'd0;
    localparam logic [2:0] CMD_BUILD  = 3'd1;
    localparam logic [2:0] CMD_ENCODE = 3'd2;
    localparam logic [2:0] CMD_DECODE = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_BUILT = 2'd1;
    localparam logic [1:0] ST_ABSENT    = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]       command;
        logic [SYM_W-1:0] symbol_in;
        logic             bit_in;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_len;
        logic [SYM_W-1:0]  symbol_out;
        logic              symbol_valid;
    } rsp_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_CLR,
        OP_RSP_ST,
        OP_CNT_RD,
        OP_CNT_WR,
        OP_ENC_RD,
        OP_ENC_CHK,
        OP_DEC_ONE,
        OP_DEC_RD,
        OP_DEC_WR,
        OP_B_INIT,
        OP_FILL_RD,
        OP_FILL_WR,
        OP_FILL_END,
        OP_EMPTY_END,
        OP_ONE_RD,
        OP_ONE_WR,
        OP_SC_RD0,
        OP_SC_INIT,
        OP_SC_RD,
        OP_SC_CMP,
        OP_POP_RD,
        OP_POP_WR,
        OP_PUSH,
        OP_ASG_INIT,
        OP_ASG_RD,
        OP_ASG_W0,
        OP_ASG_W1,
        OP_ASG_END
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] st;
        logic       rsp_push;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] command;
        logic       sym_bad;
        logic       total_full;
        logic       built;
        logic       leaf_zero;
        logic       leaf_one;
        logic       bit_one;
        logic       idx_last;
        logic       n_zero;
        logic       n_one;
        logic       k_last;
        logic       second;
        logic       p_last;
        logic       rsp_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/huffman_code_engine.sv =====
// ============================================================================
// huffman_code_engine: static Huffman coding over byte symbols
// Histogram counting, tree build by least-weight merging, code lookup and
// bit-serial tree walk decode, behind one request and one response channel.
// ============================================================================
// Every request gives exactly one response, handled one at a time. Count,
// encode and decode each step through dispatch, a registered memory read,
// update and output; a refused request skips the read and update. Clear
// sweeps the histogram memory one entry a cycle; the same sweep runs after
// reset with the request channel stalled. Build is set by the merge heap's
// single read port: a fill pass over every histogram entry, then for each
// merge two linear minimum scans over the n live heap entries, then a tree
// and node read and two child writes per internal node to assign codes.
// A finished response waits in the output register while the next request
// is taken.
`default_nettype none

module huffman_code_engine #(
    parameter int ALPHABET_SIZE = hce_pkg::ALPHABET_SIZE,
    parameter int COUNT_WIDTH   = hce_pkg::COUNT_WIDTH,
    parameter int MAX_CODE_LEN  = hce_pkg::MAX_CODE_LEN
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire hce_pkg::req_t  req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output hce_pkg::rsp_t       rsp
);

    hce_pkg::dp_cmd_t  cmd;
    hce_pkg::dp_stat_t stat;

    hce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    hce_datapath #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .COUNT_WIDTH   (COUNT_WIDTH),
        .MAX_CODE_LEN  (MAX_CODE_LEN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

endmodule

`default_nettype wire

// ===== design/hce_ctrl.sv =====
// ============================================================================
// hce_ctrl: sequencing controller of the Huffman code engine
// One-hot state machine that steps the datapath through count, build,
// encode, decode and clear, and hands each response to the output stage.
// ============================================================================
`default_nettype none

module hce_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire hce_pkg::dp_stat_t  stat,
    output hce_pkg::dp_cmd_t        cmd
);

    typedef enum logic [31:0] {
        S_SWEEP_RST = 32'd1 << 0,
        S_IDLE      = 32'd1 << 1,
        S_DISPATCH  = 32'd1 << 2,
        S_SWEEP_CMD = 32'd1 << 3,
        S_CLR_RSP   = 32'd1 << 4,
        S_CNT_RD    = 32'd1 << 5,
        S_CNT_WR    = 32'd1 << 6,
        S_ENC_RD    = 32'd1 << 7,
        S_ENC_CHK   = 32'd1 << 8,
        S_DEC_ONE   = 32'd1 << 9,
        S_DEC_RD    = 32'd1 << 10,
        S_DEC_WR    = 32'd1 << 11,
        S_B_INIT    = 32'd1 << 12,
        S_FILL_RD   = 32'd1 << 13,
        S_FILL_WR   = 32'd1 << 14,
        S_FILL_END  = 32'd1 << 15,
        S_EMPTY_END = 32'd1 << 16,
        S_ONE_RD    = 32'd1 << 17,
        S_ONE_WR    = 32'd1 << 18,
        S_SC_RD0    = 32'd1 << 19,
        S_SC_INIT   = 32'd1 << 20,
        S_SC_RD     = 32'd1 << 21,
        S_SC_CMP    = 32'd1 << 22,
        S_POP_RD    = 32'd1 << 23,
        S_POP_WR    = 32'd1 << 24,
        S_PUSH      = 32'd1 << 25,
        S_ASG_INIT  = 32'd1 << 26,
        S_ASG_RD    = 32'd1 << 27,
        S_ASG_W0    = 32'd1 << 28,
        S_ASG_W1    = 32'd1 << 29,
        S_ASG_END   = 32'd1 << 30,
        S_DONE      = 32'd1 << 31
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP_RST;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = hce_pkg::OP_NONE;
        cmd.st       = hce_pkg::ST_OK;
        cmd.rsp_push = 1'b0;
        req_stall    = 1'b1;
        case (state_reg)
            S_SWEEP_RST:
            begin
                cmd.op = hce_pkg::OP_CLR;
                if (stat.idx_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.op     = hce_pkg::OP_ACCEPT;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.op     = hce_pkg::OP_RSP_ST;
                state_next = S_DONE;
                case (stat.command)
                    hce_pkg::CMD_COUNT:
                    begin
                        if (stat.sym_bad)
                        begin
                            cmd.st = hce_pkg::ST_ABSENT;
                        end
                        else if (stat.total_full)
                        begin
                            cmd.st = hce_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.op     = hce_pkg::OP_NONE;
                            state_next = S_CNT_RD;
                        end
                    end
                    hce_pkg::CMD_BUILD:
                    begin
                        cmd.op     = hce_pkg::OP_NONE;
                        state_next = S_B_INIT;
                    end
                    hce_pkg::CMD_ENCODE:
                    begin
                        if (!stat.built)
                        begin
                            cmd.st = hce_pkg::ST_NOT_BUILT;
                        end
                        else if (stat.sym_bad)
                        begin
                            cmd.st = hce_pkg::ST_ABSENT;
                        end
                        else
                        begin
                            cmd.op     = hce_pkg::OP_NONE;
                            state_next = S_ENC_RD;
                        end
                    end
                    hce_pkg::CMD_DECODE:
                    begin
                        if (!stat.built)
                        begin
                            cmd.st = hce_pkg::ST_NOT_BUILT;
                        end
                        else if (stat.leaf_zero)
                        begin
                            cmd.st = hce_pkg::ST_ABSENT;
                        end
                        else if (stat.leaf_one)
                        begin
                            if (stat.bit_one)
                            begin
                                cmd.st = hce_pkg::ST_ABSENT;
                            end
                            else
                            begin
                                cmd.op     = hce_pkg::OP_NONE;
                                state_next = S_DEC_ONE;
                            end
                        end
                        else
                        begin
                            cmd.op     = hce_pkg::OP_NONE;
                            state_next = S_DEC_RD;
                        end
                    end
                    hce_pkg::CMD_CLEAR:
                    begin
                        cmd.op     = hce_pkg::OP_NONE;
                        state_next = S_SWEEP_CMD;
                    end
                    default:
                    begin
                        cmd.st = hce_pkg::ST_OK;
                    end
                endcase
            end
            S_SWEEP_CMD:
            begin
                cmd.op = hce_pkg::OP_CLR;
                if (stat.idx_last)
                begin
                    state_next = S_CLR_RSP;
                end
            end
            S_CLR_RSP:
            begin
                cmd.op     = hce_pkg::OP_RSP_ST;
                state_next = S_DONE;
            end
            S_CNT_RD:
            begin
                cmd.op     = hce_pkg::OP_CNT_RD;
                state_next = S_CNT_WR;
            end
            S_CNT_WR:
            begin
                cmd.op     = hce_pkg::OP_CNT_WR;
                state_next = S_DONE;
            end
            S_ENC_RD:
            begin
                cmd.op     = hce_pkg::OP_ENC_RD;
                state_next = S_ENC_CHK;
            end
            S_ENC_CHK:
            begin
                cmd.op     = hce_pkg::OP_ENC_CHK;
                state_next = S_DONE;
            end
            S_DEC_ONE:
            begin
                cmd.op     = hce_pkg::OP_DEC_ONE;
                state_next = S_DONE;
            end
            S_DEC_RD:
            begin
                cmd.op     = hce_pkg::OP_DEC_RD;
                state_next = S_DEC_WR;
            end
            S_DEC_WR:
            begin
                cmd.op     = hce_pkg::OP_DEC_WR;
                state_next = S_DONE;
            end
            S_B_INIT:
            begin
                cmd.op     = hce_pkg::OP_B_INIT;
                state_next = S_FILL_RD;
            end
            S_FILL_RD:
            begin
                cmd.op     = hce_pkg::OP_FILL_RD;
                state_next = S_FILL_WR;
            end
            S_FILL_WR:
            begin
                cmd.op     = hce_pkg::OP_FILL_WR;
                state_next = stat.idx_last ? S_FILL_END : S_FILL_RD;
            end
            S_FILL_END:
            begin
                cmd.op = hce_pkg::OP_FILL_END;
                if (stat.n_zero)
                begin
                    state_next = S_EMPTY_END;
                end
                else if (stat.n_one)
                begin
                    state_next = S_ONE_RD;
                end
                else
                begin
                    state_next = S_SC_RD0;
                end
            end
            S_EMPTY_END:
            begin
                cmd.op     = hce_pkg::OP_EMPTY_END;
                state_next = S_DONE;
            end
            S_ONE_RD:
            begin
                cmd.op     = hce_pkg::OP_ONE_RD;
                state_next = S_ONE_WR;
            end
            S_ONE_WR:
            begin
                cmd.op     = hce_pkg::OP_ONE_WR;
                state_next = S_DONE;
            end
            S_SC_RD0:
            begin
                cmd.op     = hce_pkg::OP_SC_RD0;
                state_next = S_SC_INIT;
            end
            S_SC_INIT:
            begin
                cmd.op     = hce_pkg::OP_SC_INIT;
                state_next = stat.n_one ? S_POP_RD : S_SC_RD;
            end
            S_SC_RD:
            begin
                cmd.op     = hce_pkg::OP_SC_RD;
                state_next = S_SC_CMP;
            end
            S_SC_CMP:
            begin
                cmd.op     = hce_pkg::OP_SC_CMP;
                state_next = stat.k_last ? S_POP_RD : S_SC_RD;
            end
            S_POP_RD:
            begin
                cmd.op     = hce_pkg::OP_POP_RD;
                state_next = S_POP_WR;
            end
            S_POP_WR:
            begin
                cmd.op     = hce_pkg::OP_POP_WR;
                state_next = stat.second ? S_PUSH : S_SC_RD0;
            end
            S_PUSH:
            begin
                cmd.op     = hce_pkg::OP_PUSH;
                state_next = stat.n_zero ? S_ASG_INIT : S_SC_RD0;
            end
            S_ASG_INIT:
            begin
                cmd.op     = hce_pkg::OP_ASG_INIT;
                state_next = S_ASG_RD;
            end
            S_ASG_RD:
            begin
                cmd.op     = hce_pkg::OP_ASG_RD;
                state_next = S_ASG_W0;
            end
            S_ASG_W0:
            begin
                cmd.op     = hce_pkg::OP_ASG_W0;
                state_next = S_ASG_W1;
            end
            S_ASG_W1:
            begin
                cmd.op     = hce_pkg::OP_ASG_W1;
                state_next = stat.p_last ? S_ASG_END : S_ASG_RD;
            end
            S_ASG_END:
            begin
                cmd.op     = hce_pkg::OP_ASG_END;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.rsp_busy)
                begin
                    cmd.rsp_push = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/hce_datapath.sv =====
// ============================================================================
// hce_datapath: tables, merge heap and registers of the Huffman code engine
// Histogram, merge heap, tree, node code and code table memories, the
// scan and merge registers, and the response output register.
// ============================================================================
`default_nettype none

module hce_datapath #(
    parameter int ALPHABET_SIZE = hce_pkg::ALPHABET_SIZE,
    parameter int COUNT_WIDTH   = hce_pkg::COUNT_WIDTH,
    parameter int MAX_CODE_LEN  = hce_pkg::MAX_CODE_LEN
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hce_pkg::req_t      req,
    input  wire hce_pkg::dp_cmd_t   cmd,
    output hce_pkg::dp_stat_t       stat,
    output hce_pkg::rsp_t           rsp,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall
);

    localparam int AW  = $clog2(ALPHABET_SIZE);
    localparam int NW  = hce_pkg::NODE_W;
    localparam int LW  = hce_pkg::LEN_W;
    localparam int CL  = MAX_CODE_LEN;
    localparam int KW  = COUNT_WIDTH + NW;
    localparam logic [NW-1:0] LEAF_END = NW'(ALPHABET_SIZE);
    localparam logic [AW-1:0] IDX_LAST = AW'(ALPHABET_SIZE - 1);
    localparam logic [NW-1:0] LEN_MAX  = NW'(MAX_CODE_LEN);

    logic [COUNT_WIDTH-1:0] hist_mem [ALPHABET_SIZE];
    logic [KW-1:0]          heap_mem [ALPHABET_SIZE];
    logic [2*NW-1:0]        tree_mem [ALPHABET_SIZE-1];
    logic [NW+CL-1:0]       node_mem [ALPHABET_SIZE-1];
    logic [LW+CL-1:0]       code_mem [ALPHABET_SIZE];

    logic [COUNT_WIDTH-1:0] hist_q, hist_wd;
    logic [KW-1:0]          heap_q, heap_wd;
    logic [2*NW-1:0]        tree_q, tree_wd;
    logic [NW+CL-1:0]       node_q, node_wd;
    logic [LW+CL-1:0]       code_q, code_wd;
    logic                   hist_re, hist_we, heap_re, heap_we, tree_re, tree_we;
    logic                   node_re, node_we, code_re, code_we;
    logic [AW-1:0]          hist_ra, hist_wa, heap_ra, heap_wa, tree_ra, tree_wa;
    logic [AW-1:0]          node_ra, node_wa, code_ra, code_wa;

    logic [2:0]             cmd_reg;
    logic [7:0]             sym_reg;
    logic                   bit_reg;
    logic [AW-1:0]          idx_reg;
    logic [AW:0]            n_reg;
    logic [AW:0]            k_reg;
    logic [AW-1:0]          best_reg;
    logic [KW-1:0]          best_key_reg;
    logic [KW-1:0]          fa_reg;
    logic [NW-1:0]          next_reg;
    logic [NW-1:0]          root_reg;
    logic [NW-1:0]          cursor_reg;
    logic [NW-1:0]          p_reg;
    logic [AW:0]            leaf_reg;
    logic [COUNT_WIDTH-1:0] total_reg;
    logic                   built_reg;
    logic                   too_long_reg;
    logic                   second_reg;
    hce_pkg::rsp_t          rsp_reg;
    hce_pkg::rsp_t          rsp_next;
    logic                   rsp_load;
    hce_pkg::rsp_t          out_reg;
    logic                   out_valid_reg;

    logic [AW:0]            n_dec;
    logic [NW-1:0]          cur_eff, cur_off, p_off, next_off, root_init, root_off;
    logic [NW-1:0]          dec_child;
    logic                   asg_bit;
    logic [NW-1:0]          asg_child, asg_child_off, asg_len;
    logic [CL-1:0]          asg_code;
    logic                   asg_leaf, asg_too_long;
    logic [KW-1:0]          fill_key, push_key;

    assign n_dec     = n_reg - 1'b1;
    assign cur_eff   = (cursor_reg < LEAF_END || cursor_reg > root_reg) ? root_reg : cursor_reg;
    assign cur_off   = cur_eff - LEAF_END;
    assign p_off     = p_reg - LEAF_END;
    assign next_off  = next_reg - LEAF_END;
    assign root_init = next_reg - 1'b1;
    assign root_off  = root_init - LEAF_END;
    assign dec_child = bit_reg ? tree_q[2*NW-1:NW] : tree_q[NW-1:0];

    assign asg_bit       = (cmd.op == hce_pkg::OP_ASG_W1);
    assign asg_child     = asg_bit ? tree_q[2*NW-1:NW] : tree_q[NW-1:0];
    assign asg_child_off = asg_child - LEAF_END;
    assign asg_len       = node_q[NW+CL-1:CL] + 1'b1;
    assign asg_code      = {node_q[CL-2:0], asg_bit};
    assign asg_leaf      = asg_child < LEAF_END;
    assign asg_too_long  = asg_len > LEN_MAX;

    assign fill_key = {hist_q, {(NW-AW){1'b0}}, idx_reg};
    assign push_key = {COUNT_WIDTH'(fa_reg[KW-1:NW] + best_key_reg[KW-1:NW]), next_reg};

    always_comb
    begin
        stat.command    = cmd_reg;
        stat.sym_bad    = {1'b0, sym_reg} >= LEAF_END;
        stat.total_full = &total_reg;
        stat.built      = built_reg;
        stat.leaf_zero  = leaf_reg == '0;
        stat.leaf_one   = leaf_reg == (AW+1)'(1);
        stat.bit_one    = bit_reg;
        stat.idx_last   = idx_reg == IDX_LAST;
        stat.n_zero     = n_reg == '0;
        stat.n_one      = n_reg == (AW+1)'(1);
        stat.k_last     = k_reg == n_dec;
        stat.second     = second_reg;
        stat.p_last     = p_reg == LEAF_END;
        stat.rsp_busy   = out_valid_reg && rsp_stall;
    end

    always_comb
    begin
        hist_re = 1'b0;  hist_we = 1'b0;  hist_ra = sym_reg[AW-1:0];
        hist_wa = idx_reg;  hist_wd = '0;
        heap_re = 1'b0;  heap_we = 1'b0;  heap_ra = '0;
        heap_wa = n_reg[AW-1:0];  heap_wd = fill_key;
        tree_re = 1'b0;  tree_we = 1'b0;  tree_ra = p_off[AW-1:0];
        tree_wa = next_off[AW-1:0];  tree_wd = {best_key_reg[NW-1:0], fa_reg[NW-1:0]};
        node_re = 1'b0;  node_we = 1'b0;  node_ra = p_off[AW-1:0];
        node_wa = asg_child_off[AW-1:0];  node_wd = {asg_len, asg_code};
        code_re = 1'b0;  code_we = 1'b0;  code_ra = sym_reg[AW-1:0];
        code_wa = asg_child[AW-1:0];  code_wd = {asg_len[LW-1:0], asg_code};
        case (cmd.op)
            hce_pkg::OP_CLR:
            begin
                hist_we = 1'b1;
            end
            hce_pkg::OP_CNT_RD:
            begin
                hist_re = 1'b1;
            end
            hce_pkg::OP_CNT_WR:
            begin
                hist_we = 1'b1;
                hist_wa = sym_reg[AW-1:0];
                hist_wd = hist_q + 1'b1;
            end
            hce_pkg::OP_ENC_RD:
            begin
                hist_re = 1'b1;
                code_re = 1'b1;
            end
            hce_pkg::OP_DEC_RD:
            begin
                tree_re = 1'b1;
                tree_ra = cur_off[AW-1:0];
            end
            hce_pkg::OP_FILL_RD:
            begin
                hist_re = 1'b1;
                hist_ra = idx_reg;
            end
            hce_pkg::OP_FILL_WR:
            begin
                heap_we = hist_q != '0;
            end
            hce_pkg::OP_ONE_RD, hce_pkg::OP_SC_RD0:
            begin
                heap_re = 1'b1;
            end
            hce_pkg::OP_ONE_WR:
            begin
                code_we = 1'b1;
                code_wa = heap_q[AW-1:0];
                code_wd = {LW'(1), CL'(0)};
            end
            hce_pkg::OP_SC_RD:
            begin
                heap_re = 1'b1;
                heap_ra = k_reg[AW-1:0];
            end
            hce_pkg::OP_POP_RD:
            begin
                heap_re = 1'b1;
                heap_ra = n_dec[AW-1:0];
            end
            hce_pkg::OP_POP_WR:
            begin
                heap_we = 1'b1;
                heap_wa = best_reg;
                heap_wd = heap_q;
            end
            hce_pkg::OP_PUSH:
            begin
                heap_we = 1'b1;
                heap_wd = push_key;
                tree_we = 1'b1;
            end
            hce_pkg::OP_ASG_INIT:
            begin
                node_we = 1'b1;
                node_wa = root_off[AW-1:0];
                node_wd = '0;
            end
            hce_pkg::OP_ASG_RD:
            begin
                tree_re = 1'b1;
                node_re = 1'b1;
            end
            hce_pkg::OP_ASG_W0, hce_pkg::OP_ASG_W1:
            begin
                node_we = !asg_leaf;
                code_we = asg_leaf && !asg_too_long;
            end
            default:
            begin
                hist_re = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rsp_next = '0;
        rsp_load = 1'b1;
        case (cmd.op)
            hce_pkg::OP_RSP_ST:
            begin
                rsp_next.status = cmd.st;
            end
            hce_pkg::OP_CNT_WR, hce_pkg::OP_EMPTY_END, hce_pkg::OP_ONE_WR:
            begin
                rsp_next = '0;
            end
            hce_pkg::OP_ENC_CHK:
            begin
                if (hist_q == '0)
                begin
                    rsp_next.status = hce_pkg::ST_ABSENT;
                end
                else
                begin
                    rsp_next.code_bits = hce_pkg::CODE_W'(code_q[CL-1:0]);
                    rsp_next.code_len  = code_q[LW+CL-1:CL];
                end
            end
            hce_pkg::OP_DEC_ONE:
            begin
                rsp_next.symbol_out   = root_reg[7:0];
                rsp_next.symbol_valid = 1'b1;
            end
            hce_pkg::OP_DEC_WR:
            begin
                if (dec_child < LEAF_END)
                begin
                    rsp_next.symbol_out   = dec_child[7:0];
                    rsp_next.symbol_valid = 1'b1;
                end
            end
            hce_pkg::OP_ASG_END:
            begin
                rsp_next.status = too_long_reg ? hce_pkg::ST_NOT_BUILT : hce_pkg::ST_OK;
            end
            default:
            begin
                rsp_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hist_re)
        begin
            hist_q <= hist_mem[hist_ra];
        end
        if (hist_we)
        begin
            hist_mem[hist_wa] <= hist_wd;
        end
        if (heap_re)
        begin
            heap_q <= heap_mem[heap_ra];
        end
        if (heap_we)
        begin
            heap_mem[heap_wa] <= heap_wd;
        end
        if (tree_re)
        begin
            tree_q <= tree_mem[tree_ra];
        end
        if (tree_we)
        begin
            tree_mem[tree_wa] <= tree_wd;
        end
        if (node_re)
        begin
            node_q <= node_mem[node_ra];
        end
        if (node_we)
        begin
            node_mem[node_wa] <= node_wd;
        end
        if (code_re)
        begin
            code_q <= code_mem[code_ra];
        end
        if (code_we)
        begin
            code_mem[code_wa] <= code_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            best_reg      <= '0;
            next_reg      <= LEAF_END;
            root_reg      <= '0;
            cursor_reg    <= '0;
            p_reg         <= LEAF_END;
            leaf_reg      <= '0;
            total_reg     <= '0;
            built_reg     <= 1'b0;
            too_long_reg  <= 1'b0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.rsp_push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                hce_pkg::OP_ACCEPT:
                begin
                    idx_reg <= '0;
                end
                hce_pkg::OP_CLR:
                begin
                    idx_reg    <= idx_reg + 1'b1;
                    total_reg  <= '0;
                    built_reg  <= 1'b0;
                    cursor_reg <= '0;
                    root_reg   <= '0;
                    leaf_reg   <= '0;
                end
                hce_pkg::OP_CNT_WR:
                begin
                    total_reg <= total_reg + 1'b1;
                    built_reg <= 1'b0;
                end
                hce_pkg::OP_DEC_RD:
                begin
                    cursor_reg <= cur_eff;
                end
                hce_pkg::OP_DEC_WR:
                begin
                    if (dec_child >= LEAF_END && dec_child <= root_reg)
                    begin
                        cursor_reg <= dec_child;
                    end
                    else
                    begin
                        cursor_reg <= root_reg;
                    end
                end
                hce_pkg::OP_B_INIT:
                begin
                    built_reg    <= 1'b0;
                    n_reg        <= '0;
                    idx_reg      <= '0;
                    too_long_reg <= 1'b0;
                    second_reg   <= 1'b0;
                end
                hce_pkg::OP_FILL_WR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (hist_q != '0)
                    begin
                        n_reg <= n_reg + 1'b1;
                    end
                end
                hce_pkg::OP_FILL_END:
                begin
                    leaf_reg   <= n_reg;
                    next_reg   <= LEAF_END;
                    second_reg <= 1'b0;
                end
                hce_pkg::OP_EMPTY_END:
                begin
                    root_reg   <= '0;
                    cursor_reg <= '0;
                    built_reg  <= 1'b1;
                end
                hce_pkg::OP_ONE_WR:
                begin
                    root_reg   <= heap_q[NW-1:0];
                    cursor_reg <= heap_q[NW-1:0];
                    built_reg  <= 1'b1;
                end
                hce_pkg::OP_SC_INIT:
                begin
                    best_reg <= '0;
                    k_reg    <= (AW+1)'(1);
                end
                hce_pkg::OP_SC_CMP:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (heap_q < best_key_reg)
                    begin
                        best_reg <= k_reg[AW-1:0];
                    end
                end
                hce_pkg::OP_POP_WR:
                begin
                    n_reg      <= n_dec;
                    second_reg <= !second_reg;
                end
                hce_pkg::OP_PUSH:
                begin
                    n_reg    <= n_reg + 1'b1;
                    next_reg <= next_reg + 1'b1;
                end
                hce_pkg::OP_ASG_INIT:
                begin
                    root_reg   <= root_init;
                    cursor_reg <= root_init;
                    p_reg      <= root_init;
                end
                hce_pkg::OP_ASG_W0:
                begin
                    if (asg_leaf && asg_too_long)
                    begin
                        too_long_reg <= 1'b1;
                    end
                end
                hce_pkg::OP_ASG_W1:
                begin
                    p_reg <= p_reg - 1'b1;
                    if (asg_leaf && asg_too_long)
                    begin
                        too_long_reg <= 1'b1;
                    end
                end
                hce_pkg::OP_ASG_END:
                begin
                    built_reg <= !too_long_reg;
                end
                default:
                begin
                    total_reg <= total_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rsp_push)
        begin
            out_reg <= rsp_reg;
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
        case (cmd.op)
            hce_pkg::OP_ACCEPT:
            begin
                cmd_reg <= req.command;
                sym_reg <= req.symbol_in;
                bit_reg <= req.bit_in;
            end
            hce_pkg::OP_SC_INIT:
            begin
                best_key_reg <= heap_q;
            end
            hce_pkg::OP_SC_CMP:
            begin
                if (heap_q < best_key_reg)
                begin
                    best_key_reg <= heap_q;
                end
            end
            hce_pkg::OP_POP_WR:
            begin
                if (!second_reg)
                begin
                    fa_reg <= best_key_reg;
                end
            end
            default:
            begin
                fa_reg <= fa_reg;
            end
        endcase
    end

    assign rsp       = out_reg;
    assign rsp_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== design/hce_checker.sv =====
// ============================================================================
// hce_checker: port-level checks of the Huffman code engine
// Response consistency and handshake behavior seen at the top-level ports.
// ============================================================================
`default_nettype none

module hce_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_stall,
    input wire hce_pkg::req_t req,
    input wire logic          rsp_valid,
    input wire logic          rsp_stall,
    input wire hce_pkg::rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while another is in work");

    a_symbol_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.symbol_valid |-> rsp.status == hce_pkg::ST_OK && rsp.code_len == '0)
        else $error("decoded symbol with bad status or a code");

    a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != hce_pkg::ST_OK
        |-> rsp.code_bits == '0 && rsp.code_len == '0 && !rsp.symbol_valid)
        else $error("failed response carries data");

    a_code_fits: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (64'(rsp.code_bits) >> rsp.code_len) == 64'd0)
        else $error("code bits beyond code length");

endmodule

bind huffman_code_engine hce_checker u_hce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire
